### sv/pbfd_pkg.sv
package pbfd_pkg;

    // Default build constants
    localparam int MAX_KEY_BYTES_DEF = 10;
    localparam int LENGTH_BITS_DEF   = 32;

    // Fixed widths of the wire format
    localparam int BYTE_W    = 8;
    localparam int VBITS     = 7;   // payload bits per varint byte
    localparam int TARGET_W  = 29;
    localparam int KV_W      = 64;  // key value is kept to 64 bits
    localparam int WIRE_BITS = 3;
    localparam logic [WIRE_BITS-1:0] WIRE_MASK = 3'h7;

    // Parser phases
    localparam logic [2:0] PH_KEY    = 3'd0;
    localparam logic [2:0] PH_VARINT = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_DRAIN  = 3'd4;

    // Wire types
    localparam logic [WIRE_BITS-1:0] WT_VARINT = 3'd0;
    localparam logic [WIRE_BITS-1:0] WT_FIX64  = 3'd1;
    localparam logic [WIRE_BITS-1:0] WT_LEN    = 3'd2;
    localparam logic [WIRE_BITS-1:0] WT_FIX32  = 3'd5;

    // Fixed payload sizes in bytes
    localparam int FIX64_BYTES = 8;
    localparam int FIX32_BYTES = 4;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

### sv/protobuf_field_delete_filter.sv
// Protobuf field delete filter. Streams a wire-format message in one byte per
// word and passes it on, dropping every field whose number equals target_field
// (0 drops nothing). A key is held until its last byte and then released as a
// whole burst, so the output side needs one cycle per released byte while
// res_stall is low: a key of k bytes ends with k words leaving back to back
// and the input stalled until the last of them leaves. The rate is set by
// the single-word result register behind a shifting burst
// buffer of MAX_KEY_BYTES entries. Malformed input (group or unknown wire type,
// overlong key, oversize length, truncation) raises error on every remaining
// word of the message and drops everything up to in_last. The word carrying
// in_last always produces at least one result; if nothing is kept, it is a
// word with out_valid low. target_field may only be written while idle.
module protobuf_field_delete_filter
    import pbfd_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [TARGET_W-1:0] cfg_wr_data,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic                in_last,
    // result channel
    output logic                res_valid,
    input  logic                res_stall,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                out_valid,
    output logic                out_last,
    output logic                error
);

    localparam int KCW     = $clog2(MAX_KEY_BYTES + 1);
    localparam int SHIFT_W = $clog2(VBITS * MAX_KEY_BYTES + 1);
    localparam int KV_WIDE = KV_W + VBITS;
    localparam int LEN_WIDE = LENGTH_BITS + VBITS * MAX_KEY_BYTES;
    localparam int FIELD_W = KV_W - WIRE_BITS;

    // Configuration
    logic [TARGET_W-1:0]    target_reg;

    // Parser state
    logic [2:0]             phase_reg, phase_next;
    byte_t                  hold_reg [MAX_KEY_BYTES];
    byte_t                  hold_next [MAX_KEY_BYTES];
    logic [KCW-1:0]         key_count_reg, key_count_next;
    logic [KV_W-1:0]        key_value_reg, key_value_next;
    logic                   drop_reg, drop_next;
    logic [LENGTH_BITS-1:0] accum_reg, accum_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic                   err_reg, err_next;

    // Burst buffer between parser and result register
    byte_t                  burst_reg [MAX_KEY_BYTES];
    byte_t                  load_data [MAX_KEY_BYTES];
    logic [KCW-1:0]         burst_cnt_reg, burst_cnt_next;
    logic                   burst_kept_reg, burst_kept_next;
    logic                   burst_last_reg, burst_last_next;
    logic                   burst_err_reg, burst_err_next;

    // Result register
    logic                   res_valid_reg;
    byte_t                  out_byte_reg;
    logic                   out_valid_reg;
    logic                   out_last_reg;
    logic                   error_reg;

    // Handshake
    logic                   out_free;
    logic                   burst_pop;
    logic                   in_acc;

    // Step datapath
    logic [VBITS-1:0]       vbits;
    logic [SHIFT_W-1:0]     vshift;
    logic [KV_WIDE-1:0]     kv_wide;
    logic [LEN_WIDE-1:0]    len_wide;
    logic [KCW-1:0]         cnt_inc;
    logic [KV_W-1:0]        kv_acc;
    logic [LENGTH_BITS-1:0] left_dec;
    logic                   key_rel;
    logic                   emit_one;
    logic                   empty_res;
    logic                   fail;

    assign out_free  = !res_valid_reg || !res_stall;
    assign burst_pop = (burst_cnt_reg != '0) && out_free;
    assign in_stall  = !((burst_cnt_reg == '0) ||
                         ((burst_cnt_reg == KCW'(1)) && out_free));
    assign in_acc    = in_valid && !in_stall;

    // Varint byte placement
    assign vbits    = in_byte[VBITS-1:0];
    assign vshift   = SHIFT_W'(key_count_reg) * SHIFT_W'(VBITS);
    assign kv_wide  = KV_WIDE'(vbits) << vshift;
    assign len_wide = LEN_WIDE'(vbits) << vshift;
    assign cnt_inc  = key_count_reg + KCW'(1);
    assign kv_acc   = key_value_reg | kv_wide[KV_W-1:0];
    assign left_dec = left_reg - LENGTH_BITS'(left_reg != '0);

    // Held key with the current byte written in
    always_comb
    begin
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            hold_next[i] = (key_count_reg == KCW'(i)) ? in_byte : hold_reg[i];
        end
    end

    // Parser step for one accepted word
    always_comb
    begin
        phase_next     = phase_reg;
        key_count_next = key_count_reg;
        key_value_next = key_value_reg;
        drop_next      = drop_reg;
        accum_next     = accum_reg;
        left_next      = left_reg;
        key_rel        = 1'b0;
        emit_one       = 1'b0;
        fail           = 1'b0;

        case (phase_reg)
            PH_KEY:
            begin
                if (key_count_reg >= KCW'(MAX_KEY_BYTES))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    key_value_next = kv_acc;
                    key_count_next = cnt_inc;
                    if (in_byte[BYTE_W-1])
                    begin
                        if (cnt_inc >= KCW'(MAX_KEY_BYTES))
                        begin
                            fail = 1'b1;
                        end
                    end
                    else
                    begin
                        drop_next = (target_reg != '0) &&
                                    (kv_acc[KV_W-1:WIRE_BITS] == FIELD_W'(target_reg));
                        case (kv_acc[WIRE_BITS-1:0] & WIRE_MASK)
                            WT_VARINT: phase_next = PH_VARINT;
                            WT_FIX64:
                            begin
                                phase_next = PH_BODY;
                                left_next  = LENGTH_BITS'(FIX64_BYTES);
                            end
                            WT_LEN:
                            begin
                                phase_next = PH_LENGTH;
                                accum_next = '0;
                            end
                            WT_FIX32:
                            begin
                                phase_next = PH_BODY;
                                left_next  = LENGTH_BITS'(FIX32_BYTES);
                            end
                            default: fail = 1'b1;
                        endcase
                        if (!fail)
                        begin
                            key_rel        = !drop_next;
                            key_count_next = '0;
                            key_value_next = '0;
                        end
                    end
                end
            end
            PH_VARINT:
            begin
                emit_one = !drop_reg;
                if (!in_byte[BYTE_W-1])
                begin
                    phase_next = PH_KEY;
                end
            end
            PH_LENGTH:
            begin
                emit_one = !drop_reg;
                if (key_count_reg >= KCW'(MAX_KEY_BYTES))
                begin
                    fail = 1'b1;
                end
                else if (|len_wide[LEN_WIDE-1:LENGTH_BITS])
                begin
                    fail = 1'b1;
                end
                else
                begin
                    accum_next     = accum_reg | len_wide[LENGTH_BITS-1:0];
                    key_count_next = cnt_inc;
                    if (in_byte[BYTE_W-1])
                    begin
                        if (cnt_inc >= KCW'(MAX_KEY_BYTES))
                        begin
                            fail = 1'b1;
                        end
                    end
                    else
                    begin
                        key_count_next = '0;
                        if (accum_next == '0)
                        begin
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            left_next  = accum_next;
                            phase_next = PH_BODY;
                        end
                    end
                end
            end
            PH_BODY:
            begin
                emit_one  = !drop_reg;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_KEY;
                end
            end
            default: phase_next = PH_DRAIN;
        endcase

        if (fail)
        begin
            phase_next = PH_DRAIN;
        end

        // error flag seen by this word's results
        err_next = err_reg || fail ||
                   (in_last && ((phase_next != PH_KEY) || (key_count_next != '0)));
    end

    // Results of this word as a burst
    assign empty_res = in_last && !key_rel && !emit_one;

    always_comb
    begin
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            load_data[i] = hold_next[i];
        end
        if (!key_rel)
        begin
            load_data[0] = empty_res ? '0 : in_byte;
        end
    end

    always_comb
    begin
        burst_cnt_next  = burst_cnt_reg - KCW'(burst_pop);
        burst_kept_next = burst_kept_reg;
        burst_last_next = burst_last_reg;
        burst_err_next  = burst_err_reg;
        if (in_acc)
        begin
            if (key_rel)
            begin
                burst_cnt_next = cnt_inc;
            end
            else if (emit_one || empty_res)
            begin
                burst_cnt_next = KCW'(1);
            end
            burst_kept_next = !empty_res;
            burst_last_next = in_last;
            burst_err_next  = err_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            target_reg <= cfg_wr_data;
        end
    end

    // Parser control state; cleared at end of message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_KEY;
            key_count_reg <= '0;
            key_value_reg <= '0;
            drop_reg      <= 1'b0;
            accum_reg     <= '0;
            left_reg      <= '0;
            err_reg       <= 1'b0;
        end
        else if (in_acc)
        begin
            if (in_last)
            begin
                phase_reg     <= PH_KEY;
                key_count_reg <= '0;
                key_value_reg <= '0;
                drop_reg      <= 1'b0;
                accum_reg     <= '0;
                left_reg      <= '0;
                err_reg       <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                key_count_reg <= key_count_next;
                key_value_reg <= key_value_next;
                drop_reg      <= drop_next;
                accum_reg     <= accum_next;
                left_reg      <= left_next;
                err_reg       <= err_next;
            end
        end
    end

    // Held key bytes
    always_ff @(posedge clk)
    begin
        if (in_acc && (phase_reg == PH_KEY))
        begin
            for (int i = 0; i < MAX_KEY_BYTES; i++)
            begin
                hold_reg[i] <= hold_next[i];
            end
        end
    end

    // Burst buffer: load on accept, shift down on pop
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < MAX_KEY_BYTES; i++)
            begin
                burst_reg[i] <= load_data[i];
            end
        end
        else if (burst_pop)
        begin
            for (int i = 0; i < MAX_KEY_BYTES - 1; i++)
            begin
                burst_reg[i] <= burst_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_cnt_reg  <= '0;
            burst_kept_reg <= 1'b0;
            burst_last_reg <= 1'b0;
            burst_err_reg  <= 1'b0;
        end
        else
        begin
            burst_cnt_reg  <= burst_cnt_next;
            burst_kept_reg <= burst_kept_next;
            burst_last_reg <= burst_last_next;
            burst_err_reg  <= burst_err_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= burst_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_pop)
        begin
            out_byte_reg  <= burst_reg[0];
            out_valid_reg <= burst_kept_reg;
            out_last_reg  <= burst_last_reg && (burst_cnt_reg == KCW'(1));
            error_reg     <= burst_err_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign error     = error_reg;

    // Checks
    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        burst_cnt_reg <= KCW'(MAX_KEY_BYTES))
        else $error("burst count above key size");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_cnt_reg > KCW'(1)) |-> in_stall)
        else $error("input taken while burst pending");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> out_last)
        else $error("empty result word not at end of message");

    a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_KEY) |-> (key_count_reg < KCW'(MAX_KEY_BYTES)))
        else $error("held key longer than limit");

endmodule

### sim/tb_protobuf_field_delete_filter.sv
module tb_protobuf_field_delete_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import pbfd_pkg::*;

    localparam int MAXK     = MAX_KEY_BYTES_DEF;
    localparam int LEN_BITS = LENGTH_BITS_DEF;

    // wire types the filter rejects
    localparam logic [WIRE_BITS-1:0] WT_SGROUP = 3'd3;
    localparam logic [WIRE_BITS-1:0] WT_EGROUP = 3'd4;
    localparam logic [WIRE_BITS-1:0] WT_RSVD6  = 3'd6;
    localparam logic [WIRE_BITS-1:0] WT_RSVD7  = 3'd7;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [TARGET_W-1:0] cfg_wr_data = '0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [BYTE_W-1:0]   in_byte     = '0;
    logic                in_last     = 1'b0;
    logic                res_valid;
    logic                res_stall   = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic                out_valid;
    logic                out_last;
    logic                error;

    typedef struct packed {
        byte_t data;
        logic  kept;
        logic  last;
        logic  err;
    } word_res_t;

    word_res_t expected_words[$];
    byte_t     msg_buf[$];

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_left    = 0;
    int failures     = 0;
    int words_in     = 0;
    int words_out    = 0;
    int msgs_sent    = 0;
    int msgs_flagged = 0;

    // filter model state
    logic [TARGET_W-1:0] strip_field = '0;
    logic [2:0]          ph          = PH_KEY;
    byte_t               held[MAXK];
    int unsigned         held_n      = 0;
    logic [63:0]         key_acc     = '0;
    logic [63:0]         len_acc     = '0;
    logic [63:0]         remain      = '0;
    logic                drop_fld    = 1'b0;
    logic                err_seen    = 1'b0;

    protobuf_field_delete_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .out_byte    (out_byte),
        .out_valid   (out_valid),
        .out_last    (out_last),
        .error       (error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void abort_message();
        err_seen = 1'b1;
        ph = PH_DRAIN;
    endfunction

    // work out the result words that one input word releases
    task automatic filter_word(input byte_t b, input logic last);
        word_res_t   step_res[$];
        logic [6:0]  v;
        int unsigned sh;
        int          i;
        v = b[6:0];
        case (ph)
            PH_KEY:
            begin
                held[held_n] = b;
                key_acc |= 64'(v) << (7 * held_n);
                held_n++;
                if (b[7])
                begin
                    if (held_n >= MAXK)
                        abort_message();
                end
                else
                begin
                    // bits past 64 are gone; compare everything above the wire type
                    drop_fld = (strip_field != '0) && ((key_acc >> 3) == 64'(strip_field));
                    case (key_acc[2:0])
                        WT_VARINT: ph = PH_VARINT;
                        WT_FIX64:
                        begin
                            ph = PH_BODY;
                            remain = FIX64_BYTES;
                        end
                        WT_LEN:
                        begin
                            ph = PH_LENGTH;
                            len_acc = '0;
                        end
                        WT_FIX32:
                        begin
                            ph = PH_BODY;
                            remain = FIX32_BYTES;
                        end
                        default: abort_message();
                    endcase
                    if (ph != PH_DRAIN)
                    begin
                        if (!drop_fld)
                            for (i = 0; i < held_n; i++)
                                step_res.push_back(word_res_t'{held[i], 1'b1, 1'b0, 1'b0});
                        held_n = 0;
                        key_acc = '0;
                    end
                end
            end
            PH_VARINT:
            begin
                if (!drop_fld)
                    step_res.push_back(word_res_t'{b, 1'b1, 1'b0, 1'b0});
                if (!b[7])
                    ph = PH_KEY;
            end
            PH_LENGTH:
            begin
                // length bytes are copied even when they turn out bad
                if (!drop_fld)
                    step_res.push_back(word_res_t'{b, 1'b1, 1'b0, 1'b0});
                sh = 7 * held_n;
                if ((sh >= LEN_BITS && v != 0) ||
                    (sh < LEN_BITS && LEN_BITS - sh < 7 && (v >> (LEN_BITS - sh)) != 0))
                    abort_message();
                else
                begin
                    if (sh < LEN_BITS)
                        len_acc |= 64'(v) << sh;
                    held_n++;
                    if (b[7])
                    begin
                        if (held_n >= MAXK)
                            abort_message();
                    end
                    else
                    begin
                        held_n = 0;
                        if (len_acc == 0)
                            ph = PH_KEY;
                        else
                        begin
                            remain = len_acc;
                            ph = PH_BODY;
                        end
                    end
                end
            end
            PH_BODY:
            begin
                if (!drop_fld)
                    step_res.push_back(word_res_t'{b, 1'b1, 1'b0, 1'b0});
                if (remain != 0)
                    remain--;
                if (remain == 0)
                    ph = PH_KEY;
            end
            default: ph = PH_DRAIN;
        endcase

        // message cut short
        if (last && (ph != PH_KEY || held_n != 0))
            err_seen = 1'b1;
        if (last && step_res.size() == 0)
            step_res.push_back('0);
        for (i = 0; i < step_res.size(); i++)
            step_res[i].err = err_seen;
        if (last)
        begin
            step_res[step_res.size() - 1].last = 1'b1;
            msgs_flagged += err_seen;
            ph       = PH_KEY;
            held_n   = 0;
            key_acc  = '0;
            drop_fld = 1'b0;
            len_acc  = '0;
            remain   = '0;
            err_seen = 1'b0;
        end
        for (i = 0; i < step_res.size(); i++)
            expected_words.push_back(step_res[i]);
    endtask

    // receiver: random stall, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    // compare each accepted result word with the oldest expected one
    always @(posedge clk)
    begin : check_results
        word_res_t want;
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
        begin
            words_out++;
            if (expected_words.size() == 0)
            begin
                failures++;
                $error("result word with none expected: out_byte %0h out_valid %0b out_last %0b",
                       out_byte, out_valid, out_last);
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_byte !== want.data)
                begin
                    failures++;
                    $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                end
                if (out_valid !== want.kept)
                begin
                    failures++;
                    $error("out_valid: expected %0b, got %0b", want.kept, out_valid);
                end
                if (out_last !== want.last)
                begin
                    failures++;
                    $error("out_last: expected %0b, got %0b", want.last, out_last);
                end
                if (error !== want.err)
                begin
                    failures++;
                    $error("error: expected %0b, got %0b", want.err, error);
                end
            end
        end
    end

    task automatic send_word(input byte_t b, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        words_in++;
        filter_word(b, last);
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg_buf.size(); i++)
            send_word(msg_buf[i], i == msg_buf.size() - 1);
        msgs_sent++;
        msg_buf.delete();
    endtask

    // stop sending and let everything already predicted come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2 * MAXK + 4) @(posedge clk);
    endtask

    task automatic write_target(input logic [TARGET_W-1:0] field_sel);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= field_sel;
        @(posedge clk);
        strip_field = field_sel;
        cfg_wr_en   <= 1'b0;
    endtask

    // varint encoder; pad adds redundant continuation bytes, junk fills
    // the unused top bits of a ten-byte key
    task automatic add_varint(input logic [63:0] v, input int unsigned pad, input logic junk);
        byte_t enc[$];
        int    i;
        do
        begin
            enc.push_back({1'b1, v[6:0]});
            v = v >> 7;
        end
        while (v != 0);
        while (pad > 0 && enc.size() < MAXK)
        begin
            enc.push_back(8'h80);
            pad--;
        end
        if (junk && enc.size() == MAXK && $urandom_range(1))
            enc[MAXK - 1] |= {1'b0, 6'($urandom), 1'b0};
        enc[enc.size() - 1][7] = 1'b0;
        for (i = 0; i < enc.size(); i++)
            msg_buf.push_back(enc[i]);
    endtask

    function automatic int unsigned pick_pad();
        return ($urandom_range(7) == 0) ? $urandom_range(1, MAXK - 1) : 0;
    endfunction

    function automatic logic [60:0] pick_field();
        case ($urandom_range(9))
            0, 1, 2: return 61'($urandom_range(7));
            3, 4, 5: return 61'(strip_field);
            6:       return 61'($urandom & 32'h1FFF_FFFF);
            7:       return {32'($urandom_range(1, 32'h7FFF_FFFF)), strip_field};
            8:       return 61'({TARGET_W{1'b1}});
            default: return {29'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic add_field();
        logic [60:0]          fnum;
        logic [WIRE_BITS-1:0] wt;
        int unsigned          n;
        fnum = pick_field();
        case ($urandom_range(3))
            0:       wt = WT_VARINT;
            1:       wt = WT_FIX64;
            2:       wt = WT_LEN;
            default: wt = WT_FIX32;
        endcase
        add_varint({fnum, wt}, pick_pad(), 1'b1);
        case (wt)
            WT_VARINT:
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
                repeat (n - 1) msg_buf.push_back(8'($urandom_range(128, 255)));
                msg_buf.push_back(8'($urandom_range(127)));
            end
            WT_LEN:
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(6);
                add_varint(64'(n), pick_pad(), 1'b0);
                repeat (n) msg_buf.push_back(8'($urandom));
            end
            WT_FIX64: repeat (FIX64_BYTES) msg_buf.push_back(8'($urandom));
            default:  repeat (FIX32_BYTES) msg_buf.push_back(8'($urandom));
        endcase
    endtask

    task automatic build_good_message(input int unsigned n_fields);
        repeat (n_fields) add_field();
    endtask

    // up to two good fields, then something broken, then up to three trailing bytes
    task automatic build_bad_message();
        int unsigned          n;
        logic [WIRE_BITS-1:0] wt;
        repeat ($urandom_range(2)) add_field();
        case ($urandom_range(4))
            0: repeat ($urandom_range(1, 8)) msg_buf.push_back(8'($urandom));
            1:
            begin
                add_field();
                n = $urandom_range(1, msg_buf.size());
                while (msg_buf.size() > n)
                    void'(msg_buf.pop_back());
            end
            2:
            begin
                case ($urandom_range(3))
                    0:       wt = WT_SGROUP;
                    1:       wt = WT_EGROUP;
                    2:       wt = WT_RSVD6;
                    default: wt = WT_RSVD7;
                endcase
                add_varint({pick_field(), wt}, 0, 1'b1);
            end
            3: repeat ($urandom_range(MAXK, MAXK + 1)) msg_buf.push_back(8'($urandom_range(128, 255)));
            default:
            begin
                add_varint({pick_field(), WT_LEN}, 0, 1'b1);
                if ($urandom_range(1))
                begin
                    repeat (4) msg_buf.push_back(8'hFF);
                    msg_buf.push_back(8'($urandom_range(16, 127)));
                end
                else
                    repeat (MAXK) msg_buf.push_back(8'h80);
            end
        endcase
        repeat ($urandom_range(3)) msg_buf.push_back(8'($urandom));
    endtask

    // nothing removed: field 0 with a two-byte varint, then an empty length field
    task automatic test_pass_through();
        write_target('0);
        msg_buf = '{8'h00, 8'hFF, 8'h7F, 8'h1A, 8'h00};
        send_message();
    endtask

    // field 1 removed, including a ten-byte key with junk above bit 63;
    // the final byte is dropped so the message ends on an empty word
    task automatic test_field_delete();
        write_target(29'd1);
        msg_buf = '{8'h12, 8'h01, 8'hAA,
                    8'h88, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7E,
                    8'h01};
        send_message();
    endtask

    // group wire type, oversize length and a lone key byte
    task automatic test_malformed();
        msg_buf = '{8'h0B, 8'h55};
        send_message();
        msg_buf = '{8'h12, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1F};
        send_message();
        msg_buf = '{8'h08};
        send_message();
    endtask

    // receiver holds off long enough for the filter to back up its input
    task automatic test_output_hold();
        int start;
        write_target(29'd2);
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_left    = 300;
        start        = words_in;
        while (words_in - start < 40)
        begin
            build_good_message(3);
            send_message();
        end
    endtask

    // sender waits for every result before the next message
    task automatic test_drain_pause();
        write_target(29'($urandom_range(1, 7)));
        send_gap_pct = 16;
        stall_pct    = 16;
        repeat (3)
        begin
            build_good_message($urandom_range(1, 3));
            send_message();
            wait_drained();
        end
    endtask

    task automatic test_random_traffic(input logic [TARGET_W-1:0] field_sel, input int gap_pct,
                                       input int busy_pct, input int n_words);
        int start;
        write_target(field_sel);
        send_gap_pct = gap_pct;
        stall_pct    = busy_pct;
        start        = words_in;
        while (words_in - start < n_words)
        begin
            if ($urandom_range(9) < 8)
                build_good_message($urandom_range(1, 4));
            else
                build_bad_message();
            send_message();
        end
    endtask

    initial
    begin
        int drain_wait;
        drain_wait = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pass_through();
        test_field_delete();
        test_malformed();
        test_output_hold();
        test_drain_pause();
        test_random_traffic(29'd3, 0, 0, 25);
        test_random_traffic({TARGET_W{1'b1}}, 87, 0, 25);
        test_random_traffic(29'($urandom_range(1, 7)), 0, 87, 25);
        test_random_traffic(29'($urandom), 16, 16, 25);
        test_random_traffic(29'd5, 0, 0, 25);
        test_random_traffic('0, 87, 0, 25);
        test_random_traffic({TARGET_W{1'b1}}, 0, 87, 25);
        test_random_traffic(29'd1, 16, 16, 25);

        // let the tail drain, bounded
        in_valid <= 1'b0;
        while (expected_words.size() != 0 && drain_wait < 20000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (2 * MAXK + 4) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            failures++;
            $error("%0d expected result words never arrived", expected_words.size());
        end

        $display("ran %0d messages (%0d malformed or cut short): %0d words in, %0d words out",
                 msgs_sent, msgs_flagged, words_in, words_out);
        $display("targets 0, 1, 2, 3, 5, all ones and random; no idling, sender gaps, %s",
                 "receiver stalls, both, and a long output hold");
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
